>>> rtl/screen_write_pixel_renderer_unit_macros.svh
// Assertion macros for the screen write pixel renderer.
`ifndef SCREEN_WRITE_PIXEL_RENDERER_UNIT_MACROS_SVH
`define SCREEN_WRITE_PIXEL_RENDERER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SWPR_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWPR_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) a |=> b) else $error(msg);
`else
`define SWPR_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SWPR_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

>>> rtl/swpr_pkg.sv
// Package: types, constants and decode helpers of the screen write pixel renderer.
package swpr_pkg;
    localparam int SCREEN_RAM_BYTES_DEF = 16384;
    localparam int CELL_ROWS_DEF = 24;
    localparam int CELL_COLS_DEF = 32;

    typedef struct packed {
        logic       cmd;
        logic [15:0] address;
        logic [7:0] data_byte;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic       flash_phase;
    } in_item_t;

    typedef struct packed {
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
        logic [5:0] pixel_colour;
        logic       window_dirty;
        logic       last_pixel;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_COLOUR_8X1 = 3'd0,
        REG_HIRES      = 3'd1,
        REG_ALT_SCREEN = 3'd2,
        REG_EXT_PAL    = 3'd3,
        REG_HIRES_INK  = 3'd4,
        REG_HIRES_PAPER = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_JOB,
        ST_RD,
        ST_WAIT,
        ST_PIX,
        ST_NEXT
    } state_t;

    // Job kinds queued by the decoder; an item yields at most two jobs
    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_CELL,
        JOB_HIRES
    } job_kind_t;

    typedef struct packed {
        logic colour_8x1;
        logic hires;
        logic alt;
        logic ext_pal;
        logic [3:0] h_ink;
        logic [3:0] h_paper;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic decode;    // decode item, write vram, build job list
        logic job_start; // start current job
        logic rd;        // issue a vram read
        logic rd_take;   // registered read data arrives
        logic pix;       // emit one pixel
        logic next_job;  // advance to queued job
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic clearing;  // memories still being zeroed after reset
        logic has_job;
        logic job_cell;  // queued job to start is a cell redraw
        logic need_rd;   // job needs a memory read before pixels
        logic byte_done; // last pixel of current byte
        logic job_done;  // last pixel of current job
        logic more_jobs; // another job queued
    } stat_t;

    function automatic logic [7:0] scr_y(input logic [15:0] a);
        return {a[12:11], a[7:5], a[10:8]};
    endfunction

    // returns {ink, paper}
    function automatic logic [11:0] attr_decode(input logic [7:0] c, input logic ext);
        logic [5:0] ink;
        logic [5:0] paper;
        if (!ext) begin
            paper = {2'b00, c[6:3]};
            ink = {2'b00, c[6], c[2:0]};
        end
        else begin
            paper = {c[7:6], 1'b1, c[5:3]};
            ink = {c[7:6], 1'b0, c[2:0]};
        end
        return {ink, paper};
    endfunction
endpackage

>>> rtl/screen_write_pixel_renderer_unit.sv
// Top level of the screen write pixel renderer: config port, controller, datapath, output stage.
// Turns CPU writes (cmd 0) and flash items (cmd 1) into a run of pixel transactions
// (x, y, palette index), the last flagged by last_pixel. One item is handled at a
// time: states IDLE, DECODE and JOB accept, decode and set up the first job, then one
// pixel per cycle while the output is free; a cell redraw reads video RAM (states RD
// and WAIT) ahead of each of its eight bitmap rows. A hires write beside a bitmap or
// 8x1 redraw adds a second 8-pixel run; an item that draws nothing ends after JOB.
// Pixels leave through an output register in the cycle after they are made, and
// output stalls hold the generator. After reset a clearing pass zeroes video RAM and
// the attribute cache, with no transaction accepted.
// Writes below 0x4000 or at 0x8000 and up give nothing. Registers sit on an APB
// port at byte addresses 4*i; write only while idle.
`include "screen_write_pixel_renderer_unit_macros.svh"
module screen_write_pixel_renderer_unit
    import swpr_pkg::*;
#(
    parameter int SCREEN_RAM_BYTES = SCREEN_RAM_BYTES_DEF,
    parameter int CELL_ROWS = CELL_ROWS_DEF,
    parameter int CELL_COLS = CELL_COLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    cfg_t cfg_reg;
    ctrl_t ctrl;
    stat_t stat;
    logic pix_valid;
    out_item_t pix;
    out_item_t out_reg;
    logic out_valid_reg;
    logic out_free;
    reg_idx_t widx;

    assign pready = 1'b1;
    assign widx = reg_idx_t'(paddr[4:2]);

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{colour_8x1: 1'b0, hires: 1'b0, alt: 1'b0, ext_pal: 1'b0,
                         h_ink: 4'd0, h_paper: 4'd7};
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_COLOUR_8X1:  cfg_reg.colour_8x1 <= pwdata[0];
                REG_HIRES:       cfg_reg.hires <= pwdata[0];
                REG_ALT_SCREEN:  cfg_reg.alt <= pwdata[0];
                REG_EXT_PAL:     cfg_reg.ext_pal <= pwdata[0];
                REG_HIRES_INK:   cfg_reg.h_ink <= pwdata[3:0];
                REG_HIRES_PAPER: cfg_reg.h_paper <= pwdata[3:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (widx)
            REG_COLOUR_8X1:  prdata[0] = cfg_reg.colour_8x1;
            REG_HIRES:       prdata[0] = cfg_reg.hires;
            REG_ALT_SCREEN:  prdata[0] = cfg_reg.alt;
            REG_EXT_PAL:     prdata[0] = cfg_reg.ext_pal;
            REG_HIRES_INK:   prdata[3:0] = cfg_reg.h_ink;
            REG_HIRES_PAPER: prdata[3:0] = cfg_reg.h_paper;
            default:         prdata = '0;
        endcase
    end

    // Output register: a pixel may be produced whenever it is empty or draining.
    assign out_free = !out_valid_reg || out_ready;

    swpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    swpr_datapath #(
        .SCREEN_RAM_BYTES (SCREEN_RAM_BYTES),
        .CELL_ROWS        (CELL_ROWS),
        .CELL_COLS        (CELL_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_item   (in_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pix_valid) out_reg <= pix;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // A pixel is never produced into a full, stalled output register.
    `SWPR_ASSERT_IMPL(a_no_overrun, clk, rst_n, !(pix_valid && !out_free), "pixel overrun")
    // No item is taken while the output still holds a non-final pixel of a run.
    `SWPR_ASSERT_IMPL(a_accept_gap, clk, rst_n,
        !(in_valid && in_ready && out_valid && !out_data.last_pixel), "accept mid-run")
    // Accepting an item closes the input for the next cycle.
    `SWPR_ASSERT_NEXT(a_one_item, clk, rst_n, (in_valid && in_ready), !in_ready,
        "second item during decode")
endmodule

>>> rtl/swpr_ctrl.sv
// Controller state machine of the screen write pixel renderer.
module swpr_ctrl
    import swpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_free,
    input  stat_t stat,
    output ctrl_t ctrl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid && !stat.clearing) state_next = ST_DECODE;
            ST_DECODE: state_next = ST_JOB;
            ST_JOB:    state_next = !stat.has_job ? ST_IDLE :
                                    (stat.job_cell ? ST_RD : ST_PIX);
            ST_RD:     state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_PIX;
            ST_PIX:
            begin
                if (out_free)
                begin
                    if (stat.job_done)
                        state_next = stat.more_jobs ? ST_NEXT : ST_IDLE;
                    else if (stat.byte_done && stat.need_rd)
                        state_next = ST_RD;
                end
            end
            ST_NEXT:   state_next = ST_JOB;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.clearing;
                ctrl.load = in_valid && !stat.clearing;
            end
            ST_DECODE: ctrl.decode = 1'b1;
            ST_JOB:    ctrl.job_start = stat.has_job;
            ST_RD:     ctrl.rd = 1'b1;
            ST_WAIT:   ctrl.rd_take = 1'b1;
            ST_PIX:    ctrl.pix = out_free;
            ST_NEXT:   ctrl.next_job = 1'b1;
            default:   ctrl = '0;
        endcase
    end
endmodule

>>> rtl/swpr_datapath.sv
// Datapath: video RAM, attribute cache, colour state, pixel generator.
module swpr_datapath
    import swpr_pkg::*;
#(
    parameter int SCREEN_RAM_BYTES = SCREEN_RAM_BYTES_DEF,
    parameter int CELL_ROWS = CELL_ROWS_DEF,
    parameter int CELL_COLS = CELL_COLS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  in_item,
    input  ctrl_t     ctrl,
    output stat_t     stat,
    output logic      pix_valid,
    output out_item_t pix
);
    localparam int VA_W = $clog2(SCREEN_RAM_BYTES);
    localparam int AC_D = CELL_ROWS * CELL_COLS;
    localparam int AC_W = $clog2(AC_D);

    // Memories; zeroed after reset by a clearing pass, one entry per cycle
    // over the video RAM depth (the attribute cache rides along).
    logic [7:0] vram [SCREEN_RAM_BYTES];
    logic [7:0] acache [AC_D];
    logic            clr_busy_reg;
    logic [VA_W-1:0] clr_idx_reg;

    in_item_t item_reg;
    logic [7:0] last_attr_reg, last_attr_next;
    logic [5:0] ink_reg, paper_reg;
    logic [15:0] pend_addr_reg;
    logic [7:0] pend_byte_reg;

    // job queue (two entries)
    job_kind_t kind_reg [2];
    logic [8:0] jx_reg [2];
    logic [7:0] jy_reg [2];
    logic [15:0] ja_reg [2];    // vram address (cell base) for cell
    logic [7:0] jb_reg [2];     // byte to draw for byte/hires
    logic [5:0] jink_reg [2];
    logic [5:0] jpap_reg [2];
    logic [1:0] jcnt_reg;
    logic jsel_reg;

    // active job
    logic [8:0] ax_reg;
    logic [7:0] ay_reg;
    logic [7:0] sh_reg;
    logic [5:0] aink_reg, apap_reg;
    logic [2:0] bit_reg, row_reg;
    logic       is_cell_reg;
    logic [15:0] abase_reg;

    logic [7:0] rd_data_reg;

    // helpers for decode
    logic [15:0] a;
    logic [7:0] b;
    logic in_rng, bm, at0, at1, c81, hw;
    logic [15:0] a2;

    function automatic logic [AC_W-1:0] ac_idx(input logic [4:0] r, input logic [4:0] c);
        return AC_W'(r * CELL_COLS + c);
    endfunction

    always_comb
    begin
        a = item_reg.address;
        b = item_reg.data_byte;
        in_rng = (a >= 16'h4000) && (a < 16'h8000);
        bm = (a < 16'h5800 && !cfg.hires && !cfg.alt) ||
             (cfg.alt && a >= 16'h6000 && a < 16'h7800);
        at0 = !cfg.colour_8x1 && !cfg.hires && !cfg.alt && a >= 16'h5800 && a < 16'h5B00;
        at1 = cfg.alt && a >= 16'h7800 && a < 16'h7B00;
        c81 = cfg.colour_8x1 && a >= 16'h6000 && a < 16'h7800;
        hw = cfg.hires && (a < 16'h5800 || (a >= 16'h6000 && a < 16'h7800));
        a2 = a ^ 16'h2000;
    end

    // Memory lookups are registered at load time; decode uses the results.
    logic [7:0] v_a2_reg, v_pa_reg, ac_attr_reg, ac_pend_reg;
    logic [7:0] v_pa;
    logic [15:0] pa;
    logic [7:0] py;
    logic [4:0] prow_u;
    logic [4:0] arow, acol;
    assign pa = pend_addr_reg;
    assign py = scr_y(pa);

    // the item's own store lands before the 8x1 colour of the pending byte is read
    assign v_pa = (a[13:0] == (pa[13:0] | 14'h2000)) ? b : v_pa_reg;

    // lookups at load (item from ports, state stable)
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_a2_reg <= vram[VA_W'(in_item.address ^ 16'h2000)];
            v_pa_reg <= vram[VA_W'(pend_addr_reg | 16'h2000)];
        end
    end

    // attribute cache reads: the item's cell (write or flash) and the pending cell
    logic [AC_W-1:0] idx_a, idx_p, idx_f, idx_af;
    logic p_ok, a_ok, f_ok, af_ok;
    assign arow = in_item.address[9:5];
    assign acol = in_item.address[4:0];
    assign prow_u = py[7:3];
    assign idx_a = ac_idx(arow, acol);
    assign idx_p = ac_idx(prow_u, pend_addr_reg[4:0]);
    assign idx_f = ac_idx(in_item.cell_row, in_item.cell_col);
    assign a_ok = arow < 5'(CELL_ROWS);
    assign p_ok = prow_u < 5'(CELL_ROWS);
    assign f_ok = in_item.cell_row < 5'(CELL_ROWS);
    assign idx_af = in_item.cmd ? idx_f : idx_a;
    assign af_ok = in_item.cmd ? f_ok : a_ok;
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ac_attr_reg <= af_ok ? acache[idx_af] : 8'h00;
            ac_pend_reg <= p_ok ? acache[idx_p] : 8'h00;
        end
    end

    // decode: state update and job building (combinational next values)
    logic [1:0] njobs;
    job_kind_t nk [2];
    logic [8:0] nx [2];
    logic [7:0] ny [2];
    logic [15:0] na [2];
    logic [7:0] nb [2];
    logic [5:0] ni [2];
    logic [5:0] np [2];
    logic [5:0] ink_n, pap_n;
    logic [15:0] pend_a_n;
    logic [7:0] pend_b_n;
    logic ac_we, vr_we;
    logic [11:0] dec;

    // bitmap write onto job slot helper is written inline below
    always_comb
    begin
        logic [15:0] wa;
        logic [7:0] wb;
        logic do_bm;
        logic do_h2;
        logic [7:0] c;
        logic [15:0] ac;
        logic [8:0] hx;
        logic [4:0] fr;
        logic [15:0] cb;
        njobs = 2'd0;
        for (int j = 0; j < 2; j++)
        begin
            nk[j] = JOB_BYTE; nx[j] = '0; ny[j] = '0; na[j] = '0;
            nb[j] = '0; ni[j] = '0; np[j] = '0;
        end
        ink_n = ink_reg;
        pap_n = paper_reg;
        last_attr_next = last_attr_reg;
        pend_a_n = pend_addr_reg;
        pend_b_n = pend_byte_reg;
        ac_we = 1'b0;
        vr_we = 1'b0;
        wa = a;
        wb = b;
        do_bm = 1'b0;
        do_h2 = 1'b0;
        dec = '0;
        c = '0;
        ac = '0;
        hx = '0;
        fr = '0;
        cb = cfg.alt ? 16'h6000 : 16'h4000;
        if (!item_reg.cmd)
        begin
            if (in_rng)
            begin
                vr_we = 1'b1;
                if (bm)
                begin
                    do_bm = 1'b1;
                end
                else if (at0 || at1)
                begin
                    if (a[9:5] < 5'(CELL_ROWS) && ac_attr_reg != b)
                    begin
                        ac_we = 1'b1;
                        last_attr_next = b;
                        dec = attr_decode(b, cfg.ext_pal);
                        ink_n = dec[11:6];
                        pap_n = dec[5:0];
                        nk[0] = JOB_CELL;
                        nx[0] = {a[4:0], 3'b000} & 9'h0FF;
                        ny[0] = {a[9:5], 3'b000};
                        na[0] = cb | {3'b000, a[9:8], 3'b000, a[7:5], a[4:0]};
                        ni[0] = ink_n;
                        np[0] = pap_n;
                        njobs = 2'd1;
                    end
                end
                else if (c81)
                begin
                    wa = a2;
                    wb = v_a2_reg;
                    if (!cfg.hires) do_bm = 1'b1;
                    else do_h2 = 1'b1;
                end
                if (do_bm && pend_addr_reg != wa)
                begin
                    if (!cfg.colour_8x1)
                    begin
                        c = ac_pend_reg;
                        if (last_attr_reg != c)
                        begin
                            last_attr_next = c;
                            dec = attr_decode(c, cfg.ext_pal);
                            ink_n = dec[11:6];
                            pap_n = dec[5:0];
                        end
                    end
                    else
                    begin
                        last_attr_next = v_pa;
                        dec = attr_decode(v_pa, cfg.ext_pal);
                        ink_n = dec[11:6];
                        pap_n = dec[5:0];
                    end
                    nk[0] = JOB_BYTE;
                    nx[0] = {1'b0, pa[4:0], 3'b000};
                    ny[0] = py;
                    nb[0] = pend_byte_reg;
                    ni[0] = ink_n;
                    np[0] = pap_n;
                    njobs = 2'd1;
                    pend_a_n = wa;
                end
                if (do_bm) pend_b_n = wb;
                if (do_h2)
                begin
                    ac = wa & 16'hDFFF;
                    hx = {1'b0, ac[4:0], 3'b000};
                    if (hx > 9'd7) hx = {ac[4:0], 4'b0000};
                    nk[0] = JOB_HIRES;
                    nx[0] = hx + (wa[13] ? 9'd8 : 9'd0);
                    ny[0] = scr_y(ac);
                    nb[0] = wb;
                    ni[0] = {2'b00, cfg.h_ink};
                    np[0] = {2'b00, cfg.h_paper};
                    ink_n = 6'd0;
                    pap_n = 6'd7;
                    njobs = 2'd1;
                end
                if (hw)
                begin
                    ac = a & 16'hDFFF;
                    hx = {1'b0, ac[4:0], 3'b000};
                    if (hx > 9'd7) hx = {ac[4:0], 4'b0000};
                    nk[njobs[0]] = JOB_HIRES;
                    nx[njobs[0]] = hx + (a[13] ? 9'd8 : 9'd0);
                    ny[njobs[0]] = scr_y(ac);
                    nb[njobs[0]] = b;
                    ni[njobs[0]] = {2'b00, cfg.h_ink};
                    np[njobs[0]] = {2'b00, cfg.h_paper};
                    ink_n = 6'd0;
                    pap_n = 6'd7;
                    njobs = njobs + 2'd1;
                end
            end
        end
        else
        begin
            fr = item_reg.cell_row;
            if (!cfg.colour_8x1 && !cfg.hires && !cfg.ext_pal &&
                fr < 5'(CELL_ROWS) && ac_attr_reg[7])
            begin
                dec = attr_decode(ac_attr_reg, 1'b0);
                nk[0] = JOB_CELL;
                nx[0] = {1'b0, item_reg.cell_col, 3'b000};
                ny[0] = {fr, 3'b000};
                na[0] = cb | {3'b000, fr[4:3], 3'b000, fr[2:0], item_reg.cell_col};
                ni[0] = item_reg.flash_phase ? dec[5:0] : dec[11:6];
                np[0] = item_reg.flash_phase ? dec[11:6] : dec[5:0];
                njobs = 2'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_attr_reg <= '0;
            ink_reg <= '0;
            paper_reg <= '0;
            pend_addr_reg <= '0;
            pend_byte_reg <= '0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
            jcnt_reg <= '0;
            jsel_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + VA_W'(1);
                if (clr_idx_reg == VA_W'(SCREEN_RAM_BYTES - 1)) clr_busy_reg <= 1'b0;
            end
            if (ctrl.decode)
            begin
                last_attr_reg <= last_attr_next;
                ink_reg <= ink_n;
                paper_reg <= pap_n;
                pend_addr_reg <= pend_a_n;
                pend_byte_reg <= pend_b_n;
                jcnt_reg <= njobs;
                jsel_reg <= 1'b0;
            end
            else if (ctrl.next_job)
            begin
                jsel_reg <= 1'b1;
            end
            else if (ctrl.pix && stat.job_done)
            begin
                jcnt_reg <= jcnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load) item_reg <= in_item;
        if (clr_busy_reg)
        begin
            vram[clr_idx_reg] <= 8'h00;
            if (clr_idx_reg < VA_W'(AC_D)) acache[AC_W'(clr_idx_reg)] <= 8'h00;
        end
        else if (ctrl.decode)
        begin
            if (vr_we) vram[VA_W'(a)] <= b;
            if (ac_we) acache[ac_idx(a[9:5], a[4:0])] <= b;
            for (int j = 0; j < 2; j++)
            begin
                kind_reg[j] <= nk[j]; jx_reg[j] <= nx[j]; jy_reg[j] <= ny[j];
                ja_reg[j] <= na[j]; jb_reg[j] <= nb[j];
                jink_reg[j] <= ni[j]; jpap_reg[j] <= np[j];
            end
        end
    end

    // active job and pixel generator
    logic [15:0] rd_addr;
    assign rd_addr = abase_reg + {5'd0, row_reg, 8'd0};
    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_data_reg <= vram[VA_W'(rd_addr)];
        end
        if (ctrl.job_start)
        begin
            is_cell_reg <= (kind_reg[jsel_reg] == JOB_CELL);
            ax_reg <= jx_reg[jsel_reg];
            ay_reg <= jy_reg[jsel_reg];
            abase_reg <= ja_reg[jsel_reg];
            sh_reg <= jb_reg[jsel_reg];
            aink_reg <= jink_reg[jsel_reg];
            apap_reg <= jpap_reg[jsel_reg];
            bit_reg <= '0;
            row_reg <= '0;
        end
        else if (ctrl.rd_take)
        begin
            sh_reg <= rd_data_reg;
        end
        else if (ctrl.pix)
        begin
            sh_reg <= {sh_reg[6:0], 1'b0};
            bit_reg <= bit_reg + 3'd1;
            if (bit_reg == 3'd7)
            begin
                row_reg <= row_reg + 3'd1;
                ay_reg <= ay_reg + 8'd1;
            end
        end
    end

    assign stat.clearing = clr_busy_reg;
    assign stat.has_job = jcnt_reg != 2'd0;
    assign stat.job_cell = kind_reg[jsel_reg] == JOB_CELL;
    assign stat.need_rd = is_cell_reg;
    assign stat.byte_done = bit_reg == 3'd7;
    assign stat.job_done = (bit_reg == 3'd7) && (!is_cell_reg || row_reg == 3'd7);
    assign stat.more_jobs = (jcnt_reg == 2'd2) && !jsel_reg;

    assign pix_valid = ctrl.pix;
    always_comb
    begin
        pix.pixel_x = ax_reg + {6'd0, bit_reg};
        pix.pixel_y = ay_reg;
        pix.pixel_colour = sh_reg[7] ? aink_reg : apap_reg;
        pix.window_dirty = 1'b1;
        pix.last_pixel = stat.job_done && !stat.more_jobs;
    end
endmodule

>>> bench/swpr_checker.sv
// Scoreboard for the screen write pixel renderer: pixel prediction and output compare.
`timescale 1ns / 1ps
module swpr_checker
    import swpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);
    cfg_t       cfg;
    logic [7:0] vram [16384];
    logic [7:0] attr_cache [768];
    logic [7:0] last_attr;
    logic [5:0] cur_ink;
    logic [5:0] cur_paper;
    logic [15:0] pend_addr;
    logic [7:0] pend_byte;
    out_item_t  pixel_q [$];

    function automatic logic [7:0] screen_y(input logic [15:0] a);
        return {a[12:11], a[7:5], a[10:8]};
    endfunction

    task automatic set_colours(input logic [7:0] c);
        if (!cfg.ext_pal) begin
            cur_paper = {2'b00, c[6:3]};
            cur_ink   = {2'b00, c[6], c[2:0]};
        end
        else begin
            cur_paper = {c[7:6], 1'b1, c[5:3]};
            cur_ink   = {c[7:6], 1'b0, c[2:0]};
        end
    endtask

    task automatic put_byte(input int x, input int y, input logic [7:0] b,
                            input logic [5:0] ink, input logic [5:0] paper);
        out_item_t p;
        for (int i = 0; i < 8; i++)
        begin
            p.pixel_x = 9'(x + i);
            p.pixel_y = 8'(y);
            p.pixel_colour = b[7 - i] ? ink : paper;
            p.window_dirty = 1'b1;
            p.last_pixel = 1'b0;
            pixel_q.push_back(p);
        end
    endtask

    task automatic put_cell(input int row, input int col,
                            input logic [5:0] ink, input logic [5:0] paper);
        logic [15:0] a;
        a = (cfg.alt ? 16'h6000 : 16'h4000) | 16'((row & 7) << 5)
            | 16'((row & 'h18) << 8) | 16'(col);
        for (int k = 0; k < 8; k++)
            put_byte(col * 8, row * 8 + k, vram[14'(a + k * 256)], ink, paper);
    endtask

    // delayed bitmap draw: flush the pending byte, new one becomes pending
    task automatic bitmap_store(input logic [15:0] a, input logic [7:0] b);
        logic [7:0] y;
        logic [7:0] c;
        int row;
        if (pend_addr != a)
        begin
            y = screen_y(pend_addr);
            row = y >> 3;
            if (!cfg.colour_8x1)
            begin
                c = (row < 24) ? attr_cache[row * 32 + pend_addr[4:0]] : 8'h00;
                if (last_attr != c)
                begin
                    last_attr = c;
                    set_colours(c);
                end
            end
            else
            begin
                last_attr = vram[14'(pend_addr | 16'h2000)];
                set_colours(last_attr);
            end
            put_byte(pend_addr[4:0] * 8, y, pend_byte, cur_ink, cur_paper);
            pend_addr = a;
        end
        pend_byte = b;
    endtask

    task automatic attr_store(input logic [15:0] a, input logic [7:0] b);
        int row;
        row = a[9:5];
        if (row < 24 && attr_cache[row * 32 + a[4:0]] != b)
        begin
            attr_cache[row * 32 + a[4:0]] = b;
            last_attr = b;
            set_colours(b);
            put_cell(row, a[4:0], cur_ink, cur_paper);
        end
    endtask

    task automatic hires_draw(input logic [15:0] a, input logic [7:0] b);
        logic [15:0] ac;
        int x;
        ac = a & 16'hDFFF;
        x = ac[4:0] * 8;
        cur_ink = 6'd0;
        cur_paper = 6'd7;
        if (x > 7)
            x = x * 2;
        put_byte(x + (a[13] ? 8 : 0), screen_y(ac), b, 6'(cfg.h_ink), 6'(cfg.h_paper));
    endtask

    task automatic predict_pixels(input in_item_t it);
        int q_start;
        logic [15:0] a;
        logic [7:0] c;
        q_start = pixel_q.size();
        a = it.address;
        if (!it.cmd)
        begin
            if (a >= 16'h4000 && a < 16'h8000)
            begin
                vram[a[13:0]] = it.data_byte;
                if ((a < 16'h5800 && !cfg.hires && !cfg.alt) ||
                    (cfg.alt && a >= 16'h6000 && a < 16'h7800))
                    bitmap_store(a, it.data_byte);
                else if (!cfg.colour_8x1 && !cfg.hires && !cfg.alt &&
                         a >= 16'h5800 && a < 16'h5B00)
                    attr_store(a, it.data_byte);
                else if (cfg.alt && a >= 16'h7800 && a < 16'h7B00)
                    attr_store(a, it.data_byte);
                else if (cfg.colour_8x1 && a >= 16'h6000 && a < 16'h7800)
                begin
                    // attribute bank write redraws the matching bitmap byte
                    if (!cfg.hires)
                        bitmap_store(a ^ 16'h2000, vram[a[13:0] ^ 14'h2000]);
                    else
                        hires_draw(a ^ 16'h2000, vram[a[13:0] ^ 14'h2000]);
                end
                if (cfg.hires && (a < 16'h5800 || (a >= 16'h6000 && a < 16'h7800)))
                    hires_draw(a, it.data_byte);
            end
        end
        else if (!cfg.colour_8x1 && !cfg.hires && !cfg.ext_pal && it.cell_row < 24)
        begin
            c = attr_cache[it.cell_row * 32 + it.cell_col];
            if (c[7])
            begin
                if (it.flash_phase)
                    put_cell(it.cell_row, it.cell_col, {2'b00, c[6:3]},
                             {2'b00, c[6], c[2:0]});
                else
                    put_cell(it.cell_row, it.cell_col, {2'b00, c[6], c[2:0]},
                             {2'b00, c[6:3]});
            end
        end
        if (pixel_q.size() > q_start)
            pixel_q[pixel_q.size() - 1].last_pixel = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            cfg = '{colour_8x1: 1'b0, hires: 1'b0, alt: 1'b0, ext_pal: 1'b0,
                    h_ink: 4'd0, h_paper: 4'd7};
            foreach (vram[i]) vram[i] = 8'h00;
            foreach (attr_cache[i]) attr_cache[i] = 8'h00;
            last_attr = 8'h00;
            cur_ink = 6'd0;
            cur_paper = 6'd0;
            pend_addr = 16'h0000;
            pend_byte = 8'h00;
            pixel_q.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_COLOUR_8X1:  cfg.colour_8x1 = pwdata[0];
                    REG_HIRES:       cfg.hires = pwdata[0];
                    REG_ALT_SCREEN:  cfg.alt = pwdata[0];
                    REG_EXT_PAL:     cfg.ext_pal = pwdata[0];
                    REG_HIRES_INK:   cfg.h_ink = pwdata[3:0];
                    REG_HIRES_PAPER: cfg.h_paper = pwdata[3:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none, actual %p", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (out_data.pixel_x !== want.pixel_x ||
                        out_data.pixel_y !== want.pixel_y ||
                        out_data.pixel_colour !== want.pixel_colour ||
                        out_data.window_dirty !== want.window_dirty ||
                        out_data.last_pixel !== want.last_pixel)
                    begin
                        $display("%0t: pixel mismatch, expected %p, actual %p",
                                 $time, want, out_data);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_pixels(in_data);
        end
        pending = pixel_q.size();
    end
endmodule

>>> bench/tb.sv
// Testbench top: stimulus, receiver stalls and verdict for the pixel renderer.
`timescale 1ns / 1ps
module tb;
    import swpr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    // receiver hold-off request from the stimulus side
    logic        hold_req;
    logic        hold_done;
    int          burst_left;

    screen_write_pixel_renderer_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    swpr_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Items: unused fields get random values so every input bit toggles.
    function automatic in_item_t mem_write(input logic [15:0] a, input logic [7:0] d);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom});
        it.cmd = 1'b0;
        it.address = a;
        it.data_byte = d;
        return it;
    endfunction

    function automatic in_item_t flash_cell(input int row, input int col, input bit ph);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom});
        it.cmd = 1'b1;
        it.cell_row = 5'(row);
        it.cell_col = 5'(col);
        it.flash_phase = ph;
        return it;
    endfunction

    // Sender: bursts of random length, random gaps in between.
    // valid stays high across back-to-back transactions within a burst.
    task automatic send(input in_item_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Register writes only when idle: drain, then let any silent item finish.
    task automatic quiesce();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_modes(input bit c81, input bit hr, input bit alt, input bit ext,
                             input logic [3:0] ink, input logic [3:0] paper);
        quiesce();
        reg_write(REG_COLOUR_8X1, 32'(c81));
        reg_write(REG_HIRES, 32'(hr));
        reg_write(REG_ALT_SCREEN, 32'(alt));
        reg_write(REG_EXT_PAL, 32'(ext));
        reg_write(REG_HIRES_INK, 32'(ink));
        reg_write(REG_HIRES_PAPER, 32'(paper));
    endtask

    // Mostly screen traffic: bitmap and attribute writes in both banks, some
    // repeats of the pending address, flash items, and a little noise.
    task automatic random_items(input int n);
        logic [15:0] last_a;
        int pick;
        last_a = 16'h4000;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                last_a = ($urandom_range(0, 1) ? 16'h4000 : 16'h6000)
                         + 16'($urandom_range(0, 16'h17FF));
                send(mem_write(last_a, 8'($urandom)));
            end
            else if (pick < 60)
                send(mem_write(($urandom_range(0, 1) ? 16'h5800 : 16'h7800)
                               + 16'($urandom_range(0, 16'h02FF)), 8'($urandom)));
            else if (pick < 70)
                send(mem_write(last_a, 8'($urandom)));
            else if (pick < 88)
                send(flash_cell($urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 1)));
            else
                send(mem_write(16'($urandom), 8'($urandom)));
        end
    endtask

    // Receiver: stretches of random stalls alternate with stall-free stretches.
    // One long hold-off on request lets the block back up into its input.
    initial
    begin
        int stretch;
        bit stalls;
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch = $urandom_range(10, 80);
            stalls = $urandom_range(0, 1);
            while (stretch > 0)
            begin
                if (hold_req && !hold_done)
                begin
                    out_ready <= 1'b0;
                    repeat (600) @(posedge clk);
                    hold_done = 1'b1;
                end
                out_ready <= stalls ? ($urandom_range(0, 2) != 0) : 1'b1;
                @(posedge clk);
                stretch--;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, default modes
        send(mem_write(16'h0000, 8'hFF));        // low write, ignored
        send(mem_write(16'h3FFF, 8'h5A));
        send(mem_write(16'h8000, 8'hA5));        // above screen RAM, ignored
        send(mem_write(16'hFFFF, 8'h00));
        send(mem_write(16'h4000, 8'hFF));        // first flush of the reset pending byte
        send(mem_write(16'h4000, 8'h0F));        // same address: no pixels
        send(mem_write(16'h57FF, 8'h81));
        send(mem_write(16'h4001, 8'h00));
        send(mem_write(16'h5800, 8'hFF));        // attribute with flash bit, bright
        send(mem_write(16'h5800, 8'hFF));        // unchanged attribute: nothing
        send(mem_write(16'h5AFF, 8'h87));
        send(mem_write(16'h5B00, 8'h12));        // past attribute area
        send(mem_write(16'h5801, 8'h38));        // no flash bit
        send(flash_cell(0, 0, 1'b0));
        send(flash_cell(0, 0, 1'b1));
        send(flash_cell(23, 31, 1'b1));
        send(flash_cell(0, 1, 1'b1));            // flash bit clear
        send(flash_cell(24, 5, 1'b0));           // row out of range
        send(flash_cell(31, 31, 1'b1));
        send(mem_write(16'h7FFF, 8'hC3));
        send(mem_write(16'h6000, 8'h3C));
        random_items(24);

        set_modes(0, 0, 0, 1, 4'd0, 4'd7);       // extended palette
        send(mem_write(16'h5820, 8'hC0));
        send(flash_cell(1, 0, 1'b1));            // no flash with extended palette
        hold_req <= 1'b1;                        // long output hold while items keep coming
        random_items(26);

        set_modes(1, 0, 0, 0, 4'd0, 4'd7);       // 8x1 colour
        random_items(26);

        set_modes(1, 1, 0, 0, 4'd15, 4'd0);      // hires plus 8x1, colour extremes
        send(mem_write(16'h4000, 8'hAA));
        send(mem_write(16'h601F, 8'h55));
        random_items(24);

        set_modes(0, 1, 0, 0, 4'd0, 4'd15);      // hires alone
        random_items(24);

        set_modes(0, 0, 1, 0, 4'd0, 4'd7);       // alternate screen
        send(mem_write(16'h7800, 8'h8F));
        send(flash_cell(0, 0, 1'b1));
        random_items(26);

        set_modes(1, 0, 1, 1, 4'd9, 4'd6);       // alternate screen, 8x1, extended
        random_items(24);

        set_modes(0, 0, 0, 0, 4'd0, 4'd7);
        random_items(24);

        quiesce();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
